[design/ohg_pkg.sv]
// Package with the widths, codes and item type of the odometry health gate.
package ohg_pkg;

    localparam int unsigned TIME_W   = 64;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned LIMIT_W  = 34;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned TRANS_W  = 31;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 34;

    localparam int unsigned IN_TDATA_W  = 2 * TIME_W + 3 * POS_W;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned OUT_TUSER_W = 3;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0]   MAX_AGE_RST   = 34'd100000000;
    localparam logic [LIMIT_W-1:0]   MAX_FUT_RST   = 34'd10000000;
    localparam logic [COUNT_W-1:0]   REC_SAMP_RST  = 16'd5;
    localparam logic [TRANS_W-1:0]   MAX_TRANS_RST = 31'd32768;
    localparam logic [2*TRANS_W-1:0] TRANS_SQ_RST  = 62'd1073741824;

    typedef enum logic [2:0] {
        DEC_ACCEPT    = 3'd0,
        DEC_STALE     = 3'd1,
        DEC_FUTURE    = 3'd2,
        DEC_ANCHOR    = 3'd3,
        DEC_RECOVER   = 3'd4,
        DEC_SILENCE   = 3'd5
    } t_decision;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_EN   = 3'd0,
        CFG_MAX_AGE   = 3'd1,
        CFG_MAX_FUT   = 3'd2,
        CFG_REC_SAMP  = 3'd3,
        CFG_MAX_TRANS = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        CMD_SAMPLE  = 1'b0,
        CMD_SILENCE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                     cmd;
        logic                     coords_valid;
        logic signed [TIME_W-1:0] receipt_time;
        logic signed [TIME_W-1:0] stamp_time;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
    } t_item;

endpackage

[design/odometry_health_gate.sv]
// Odometry health gate: age checks, fault latch and anchor-based recovery.
// Items pass through the input register, then the result register, one transaction per cycle
// unless the result side stalls; the state update for an item completes in the cycle it
// leaves the input register, bounded by three parallel 31x31 squarers, an adder and a compare.
// Reset (synchronous, active low) clears the latch, anchor flag, recovery count and last age,
// and loads the configuration registers with their default values. No clearing pass is needed.
module odometry_health_gate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample stream in.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata, low bit up: receipt_time[63:0], stamp_time[63:0], pos_x[31:0], pos_y[31:0],
    // pos_z[31:0]
    input  logic [ohg_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser, low bit up: cmd, coords_valid
    input  logic [ohg_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    // Result stream out.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata, low bit up: is_latched, anchor_present, recovery_progress[15:0], age_ns[63:0],
    // six zero bits
    output logic [ohg_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: decision[2:0]
    output logic [ohg_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser,
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ohg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ohg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ohg_pkg::*;

    // Configuration registers. The squared translation limit is computed when the limit is
    // written, so the distance test never waits on it.
    logic                   r_gate_en;
    logic [LIMIT_W-1:0]     r_max_age;
    logic [LIMIT_W-1:0]     r_max_fut;
    logic [COUNT_W-1:0]     r_rec_samp;
    logic [TRANS_W-1:0]     r_max_trans;
    logic [2*TRANS_W-1:0]   r_trans_sq;

    // Gate state.
    logic                   r_latched;
    logic                   r_anchor_valid;
    logic [POS_W-1:0]       r_anchor_x;
    logic [POS_W-1:0]       r_anchor_y;
    logic [POS_W-1:0]       r_anchor_z;
    logic [COUNT_W-1:0]     r_count;
    logic [TIME_W-1:0]      r_last_age;

    // Input register.
    logic                   r_in_valid;
    t_item                  r_item;

    // Result register.
    logic                   r_out_valid;
    t_decision              r_out_dec;
    logic                   r_out_latched;
    logic                   r_out_anchor;
    logic [COUNT_W-1:0]     r_out_prog;
    logic [TIME_W-1:0]      r_out_age;

    // Next values.
    logic                   n_latched;
    logic                   n_anchor_valid;
    logic                   n_store_anchor;
    logic [COUNT_W-1:0]     n_count;
    logic [TIME_W-1:0]      n_last_age;
    t_decision              n_dec;

    logic                   advance;
    t_cfg_idx               cfg_idx;

    // An item leaves the input register when the result register is free or being emptied.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;
    assign cfg_idx         = t_cfg_idx'(i_cfg_index);

    // ------------------------------------------------------------------
    // Age checks.
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] neg_age;
    logic              age_neg;
    logic              is_stale;
    logic              is_future;

    assign age       = r_item.receipt_time - r_item.stamp_time;
    assign neg_age   = {TIME_W{1'b0}} - age;
    assign age_neg   = age[TIME_W-1];
    // A stamp of zero or below is invalid, as are coordinates flagged non-finite.
    assign is_stale  = !r_item.coords_valid || (r_item.stamp_time == '0) ||
                       r_item.stamp_time[TIME_W-1] ||
                       (!age_neg && (age > {{(TIME_W-LIMIT_W){1'b0}}, r_max_age}));
    assign is_future = age_neg && (neg_age > {{(TIME_W-LIMIT_W){1'b0}}, r_max_fut});

    // ------------------------------------------------------------------
    // Distance from the anchor. With no anchor stored the sample itself becomes the anchor,
    // so the distance is zero. If any axis alone is beyond the limit the squares are not
    // needed; otherwise every magnitude fits in 31 bits and the sum cannot overflow 64 bits.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   ref_x;
    logic [POS_W-1:0]   ref_y;
    logic [POS_W-1:0]   ref_z;
    logic [POS_W:0]     diff_x;
    logic [POS_W:0]     diff_y;
    logic [POS_W:0]     diff_z;
    logic [POS_W:0]     mag_x;
    logic [POS_W:0]     mag_y;
    logic [POS_W:0]     mag_z;
    logic [2*TRANS_W-1:0] sq_x;
    logic [2*TRANS_W-1:0] sq_y;
    logic [2*TRANS_W-1:0] sq_z;
    logic [TIME_W-1:0]  sq_sum;
    logic               axis_over;
    logic               beyond;

    assign ref_x  = r_anchor_valid ? r_anchor_x : r_item.pos_x;
    assign ref_y  = r_anchor_valid ? r_anchor_y : r_item.pos_y;
    assign ref_z  = r_anchor_valid ? r_anchor_z : r_item.pos_z;

    assign diff_x = {r_item.pos_x[POS_W-1], r_item.pos_x} - {ref_x[POS_W-1], ref_x};
    assign diff_y = {r_item.pos_y[POS_W-1], r_item.pos_y} - {ref_y[POS_W-1], ref_y};
    assign diff_z = {r_item.pos_z[POS_W-1], r_item.pos_z} - {ref_z[POS_W-1], ref_z};

    assign mag_x  = diff_x[POS_W] ? ({(POS_W+1){1'b0}} - diff_x) : diff_x;
    assign mag_y  = diff_y[POS_W] ? ({(POS_W+1){1'b0}} - diff_y) : diff_y;
    assign mag_z  = diff_z[POS_W] ? ({(POS_W+1){1'b0}} - diff_z) : diff_z;

    assign axis_over = (mag_x > {2'b00, r_max_trans}) || (mag_y > {2'b00, r_max_trans}) ||
                       (mag_z > {2'b00, r_max_trans});

    assign sq_x   = mag_x[TRANS_W-1:0] * mag_x[TRANS_W-1:0];
    assign sq_y   = mag_y[TRANS_W-1:0] * mag_y[TRANS_W-1:0];
    assign sq_z   = mag_z[TRANS_W-1:0] * mag_z[TRANS_W-1:0];
    assign sq_sum = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    assign beyond = axis_over || (sq_sum > {2'b00, r_trans_sq});

    // ------------------------------------------------------------------
    // Decision and next state for the item in the input register.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] count_inc;
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_latched      = r_latched;
        n_anchor_valid = r_anchor_valid;
        n_store_anchor = 1'b0;
        n_count        = r_count;
        n_last_age     = r_last_age;
        n_dec          = DEC_ACCEPT;
        if (r_item.cmd == CMD_SILENCE) begin
            // A silence event leaves the age untouched and latches when gating is on.
            n_dec = DEC_SILENCE;
            if (r_gate_en) begin
                n_latched = 1'b1;
                n_count   = '0;
            end
        end else begin
            n_last_age = age;
            if (!r_gate_en) begin
                n_store_anchor = 1'b1;
                n_dec          = DEC_ACCEPT;
            end else if (is_stale) begin
                n_latched = 1'b1;
                n_count   = '0;
                n_dec     = DEC_STALE;
            end else if (is_future) begin
                n_latched = 1'b1;
                n_count   = '0;
                n_dec     = DEC_FUTURE;
            end else begin
                // The first fresh sample becomes the anchor whatever follows.
                if (!r_anchor_valid) begin
                    n_store_anchor = 1'b1;
                end
                if (!r_latched) begin
                    n_store_anchor = 1'b1;
                    n_dec          = DEC_ACCEPT;
                end else if (beyond) begin
                    n_count = '0;
                    n_dec   = DEC_ANCHOR;
                end else if (count_inc < r_rec_samp) begin
                    n_count = count_inc;
                    n_dec   = DEC_RECOVER;
                end else begin
                    // Enough near samples: release the latch and move the anchor here.
                    n_latched      = 1'b0;
                    n_count        = '0;
                    n_store_anchor = 1'b1;
                    n_dec          = DEC_ACCEPT;
                end
            end
        end
        if (n_store_anchor) begin
            n_anchor_valid = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_en   <= 1'b1;
            r_max_age   <= MAX_AGE_RST;
            r_max_fut   <= MAX_FUT_RST;
            r_rec_samp  <= REC_SAMP_RST;
            r_max_trans <= MAX_TRANS_RST;
            r_trans_sq  <= TRANS_SQ_RST;
        end else if (i_cfg_valid) begin
            unique case (cfg_idx)
                CFG_GATE_EN:   r_gate_en  <= i_cfg_data[0];
                CFG_MAX_AGE:   r_max_age  <= i_cfg_data[LIMIT_W-1:0];
                CFG_MAX_FUT:   r_max_fut  <= i_cfg_data[LIMIT_W-1:0];
                CFG_REC_SAMP:  r_rec_samp <= i_cfg_data[COUNT_W-1:0];
                CFG_MAX_TRANS: begin
                    r_max_trans <= i_cfg_data[TRANS_W-1:0];
                    r_trans_sq  <= i_cfg_data[TRANS_W-1:0] * i_cfg_data[TRANS_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_item.cmd          <= t_cmd'(i_s_axis_tuser[0]);
            r_item.coords_valid <= i_s_axis_tuser[1];
            r_item.receipt_time <= i_s_axis_tdata[TIME_W-1:0];
            r_item.stamp_time   <= i_s_axis_tdata[2*TIME_W-1:TIME_W];
            r_item.pos_x        <= i_s_axis_tdata[2*TIME_W+POS_W-1:2*TIME_W];
            r_item.pos_y        <= i_s_axis_tdata[2*TIME_W+2*POS_W-1:2*TIME_W+POS_W];
            r_item.pos_z        <= i_s_axis_tdata[2*TIME_W+3*POS_W-1:2*TIME_W+2*POS_W];
        end
    end

    // ------------------------------------------------------------------
    // Gate state, updated as an item moves into the result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched      <= 1'b0;
            r_anchor_valid <= 1'b0;
            r_count        <= '0;
            r_last_age     <= '0;
        end else if (advance) begin
            r_latched      <= n_latched;
            r_anchor_valid <= n_anchor_valid;
            r_count        <= n_count;
            r_last_age     <= n_last_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_store_anchor) begin
            r_anchor_x <= r_item.pos_x;
            r_anchor_y <= r_item.pos_y;
            r_anchor_z <= r_item.pos_z;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_dec     <= n_dec;
            r_out_latched <= n_latched;
            r_out_anchor  <= n_anchor_valid;
            r_out_prog    <= n_count;
            r_out_age     <= n_last_age;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_dec;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-TIME_W-COUNT_W-2){1'b0}},
                              r_out_age, r_out_prog, r_out_anchor, r_out_latched};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The recovery count only runs while the latch is set.
    a_count_needs_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_latched |-> (r_count == '0))
        else $error("recovery count nonzero while unlatched");

    // A stale or future verdict always leaves the latch set.
    a_reject_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_dec == DEC_STALE || r_out_dec == DEC_FUTURE)) |-> r_out_latched)
        else $error("age rejection reported without latch");

    // A recovering verdict reports a latched gate with some progress and an anchor.
    a_recover_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dec == DEC_RECOVER) |->
            (r_out_latched && r_out_anchor && r_out_prog != '0))
        else $error("recovering verdict with inconsistent state");

    // An item held in the input register is never dropped while the result side stalls.
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input item lost while stalled");

    // Once stored, the anchor is never forgotten.
    a_anchor_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anchor_valid |=> r_anchor_valid)
        else $error("anchor flag cleared");

endmodule
